@@ rtl/core/slrd_pkg.sv @@
`timescale 1ns / 1ps

package slrd_pkg;

    localparam int VALUE_W = 20;
    localparam int COORD_W = 16;

    // input item kinds
    localparam logic [1:0] ITEM_LAYER_START = 2'd0;
    localparam logic [1:0] ITEM_ROW_START   = 2'd1;
    localparam logic [1:0] ITEM_COMMAND     = 2'd2;
    localparam logic [1:0] ITEM_PACKED      = 2'd3;

    // command codes
    localparam logic [1:0] CMD_SKIP   = 2'd0;
    localparam logic [1:0] CMD_COPY   = 2'd1;
    localparam logic [1:0] CMD_PLAYER = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // layer modes
    localparam logic [1:0] MODE_MAIN    = 2'd0;
    localparam logic [1:0] MODE_SHADOW  = 2'd1;
    localparam logic [1:0] MODE_OUTLINE = 2'd2;

    // result kinds
    localparam logic [2:0] OUT_OPAQUE  = 3'd0;
    localparam logic [2:0] OUT_PLAYER  = 3'd1;
    localparam logic [2:0] OUT_SHADOW  = 3'd2;
    localparam logic [2:0] OUT_OUTLINE = 3'd3;
    localparam logic [2:0] OUT_INDEX   = 3'd4;

    // configuration register indexes
    localparam logic REG_LAYER_MODE = 1'b0;
    localparam logic REG_PACKED_TWO = 1'b1;

    localparam logic [15:0] TRANSPARENT_EDGE = 16'hFFFF;
    localparam logic [9:0]  IDX_MASK         = 10'd1023;
    localparam logic [9:0]  HI_MASK          = 10'd768;
    localparam logic [1:0]  CODE_MASK        = 2'h3;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } slrd_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } slrd_cmd_t;

    typedef struct packed {
        logic emits;
        logic last_step;
        logic out_free;
    } slrd_status_t;

endpackage

@@ rtl/core/sprite_layer_rle_decoder.sv @@
`timescale 1ns / 1ps

// Run-length decoder for one sprite layer. Items (layer start, row start,
// command byte, packed block) arrive on a valid/ready channel; results leave
// through a single output register on a second valid/ready channel, each
// with last set on the final result of its item. An item that gives no
// result is taken in the idle state. An item that gives n results (1 to 64
// for a copy or player command, 1 for a shadow value, 2 or 4 for a packed
// block) is taken, then the emission counter steps its results into the
// output register, each step waiting on a stalled output. The next item is
// taken while the final result waits there. The user must write layer_mode
// and packed_two through the cfg port only while idle; it is not enforced.

module sprite_layer_rle_decoder #(
    parameter int ORDINAL_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] row_number,
    input  logic [15:0] left_edge,
    input  logic [7:0]  cmd_byte,
    input  logic [39:0] packed_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [19:0] value,
    output logic        last
);
    import slrd_pkg::*;

    slrd_cmd_t    cmd;
    slrd_status_t status;

    slrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slrd_datapath #(
        .ORDINAL_BITS (ORDINAL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .row_number   (row_number),
        .left_edge    (left_edge),
        .cmd_byte     (cmd_byte),
        .packed_block (packed_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .value        (value),
        .last         (last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ rtl/core/slrd_ctrl.sv @@
`timescale 1ns / 1ps

module slrd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slrd_pkg::slrd_status_t status,
    output slrd_pkg::slrd_cmd_t    cmd
);
    import slrd_pkg::*;

    slrd_state_t state_reg;
    slrd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.emits)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EMIT:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/slrd_datapath.sv @@
`timescale 1ns / 1ps

module slrd_datapath #(
    parameter int ORDINAL_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [1:0]            cfg_data,
    input  logic [1:0]            kind,
    input  logic [15:0]           row_number,
    input  logic [15:0]           left_edge,
    input  logic [7:0]            cmd_byte,
    input  logic [39:0]           packed_block,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_kind,
    output logic [15:0]           pos_x,
    output logic [15:0]           pos_y,
    output logic [19:0]           value,
    output logic                  last,
    input  slrd_pkg::slrd_cmd_t    cmd,
    output slrd_pkg::slrd_status_t status
);
    import slrd_pkg::*;

    // configuration
    logic [1:0] layer_mode_reg;
    logic       packed_two_reg;

    // decoder state
    logic                    row_active_reg, row_active_next;
    logic [15:0]             current_row_reg, current_row_next;
    logic [15:0]             column_pos_reg, column_pos_next;
    logic [ORDINAL_BITS-1:0] ordinal_reg, ordinal_next;
    logic [6:0]              shadow_rem_reg, shadow_rem_next;

    // emission run
    logic [2:0]  em_kind_reg, em_kind_next;
    logic [5:0]  cnt_m1_reg, cnt_m1_next;
    logic [5:0]  idx_reg;
    logic [7:0]  shadow_val_reg;
    logic [39:0] block_reg;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [15:0] pos_x_reg;
    logic [15:0] pos_y_reg;
    logic [19:0] value_reg;
    logic        last_reg;

    logic        emits;
    logic [1:0]  code;
    logic [5:0]  cnt_field;
    logic [19:0] ord_view;
    logic [9:0]  index_val;
    logic [19:0] value_sel;
    logic        out_free;

    assign code      = cmd_byte[1:0] & CODE_MASK;
    assign cnt_field = cmd_byte[7:2];

    generate
        if (ORDINAL_BITS >= VALUE_W)
        begin : g_ord_trunc
            assign ord_view = ordinal_reg[VALUE_W-1:0];
        end
        else
        begin : g_ord_ext
            assign ord_view = {{(VALUE_W-ORDINAL_BITS){1'b0}}, ordinal_reg};
        end
    endgenerate

    // item decode and state update on load
    always_comb
    begin
        emits            = 1'b0;
        em_kind_next     = em_kind_reg;
        cnt_m1_next      = cnt_m1_reg;
        row_active_next  = row_active_reg;
        current_row_next = current_row_reg;
        column_pos_next  = column_pos_reg;
        ordinal_next     = ordinal_reg;
        shadow_rem_next  = shadow_rem_reg;

        unique case (kind)
            ITEM_LAYER_START:
            begin
                row_active_next  = 1'b0;
                current_row_next = '0;
                column_pos_next  = '0;
                ordinal_next     = '0;
                shadow_rem_next  = '0;
            end
            ITEM_ROW_START:
            begin
                shadow_rem_next = '0;
                if (left_edge == TRANSPARENT_EDGE)
                begin
                    row_active_next = 1'b0;
                end
                else
                begin
                    row_active_next  = 1'b1;
                    current_row_next = row_number;
                    column_pos_next  = left_edge;
                end
            end
            ITEM_COMMAND:
            begin
                if (shadow_rem_reg != '0)
                begin
                    emits           = 1'b1;
                    em_kind_next    = OUT_SHADOW;
                    cnt_m1_next     = '0;
                    shadow_rem_next = shadow_rem_reg - 7'd1;
                end
                else if (row_active_reg)
                begin
                    if (code == CMD_END)
                    begin
                        row_active_next = 1'b0;
                    end
                    else if (code == CMD_SKIP)
                    begin
                        column_pos_next = column_pos_reg + {10'd0, cnt_field} + 16'd1;
                    end
                    else if (layer_mode_reg == MODE_MAIN)
                    begin
                        emits        = 1'b1;
                        em_kind_next = (code == CMD_PLAYER) ? OUT_PLAYER : OUT_OPAQUE;
                        cnt_m1_next  = cnt_field;
                    end
                    else if (code == CMD_COPY && layer_mode_reg == MODE_SHADOW)
                    begin
                        shadow_rem_next = {1'b0, cnt_field} + 7'd1;
                    end
                    else if (code == CMD_COPY && layer_mode_reg == MODE_OUTLINE)
                    begin
                        emits        = 1'b1;
                        em_kind_next = OUT_OUTLINE;
                        cnt_m1_next  = cnt_field;
                    end
                end
            end
            ITEM_PACKED:
            begin
                emits        = 1'b1;
                em_kind_next = OUT_INDEX;
                cnt_m1_next  = packed_two_reg ? 6'd1 : 6'd3;
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase

        // per-result advance during a run; the item on the input is not taken yet
        if (cmd.step)
        begin
            row_active_next  = row_active_reg;
            current_row_next = current_row_reg;
            column_pos_next  = column_pos_reg;
            ordinal_next     = ordinal_reg;
            shadow_rem_next  = shadow_rem_reg;
            if (em_kind_reg != OUT_INDEX)
            begin
                column_pos_next = column_pos_reg + 16'd1;
            end
            if (em_kind_reg == OUT_OPAQUE || em_kind_reg == OUT_PLAYER)
            begin
                ordinal_next = ordinal_reg + ORDINAL_BITS'(1);
            end
        end
    end

    // unpack one index from the held block
    always_comb
    begin
        index_val = '0;
        if (packed_two_reg)
        begin
            index_val = idx_reg[0] ? (block_reg[19:10] & IDX_MASK)
                                   : (block_reg[9:0] & IDX_MASK);
        end
        else
        begin
            case (idx_reg[1:0])
                2'd0: index_val = {block_reg[33:32], block_reg[7:0]} & IDX_MASK;
                2'd1: index_val = {block_reg[35:34], block_reg[15:8]} & IDX_MASK;
                2'd2: index_val = {block_reg[37:36], block_reg[23:16]} & IDX_MASK;
                default: index_val = {block_reg[39:38], block_reg[31:24]} & IDX_MASK;
            endcase
        end
        if ((index_val & HI_MASK) == '0)
        begin
            index_val = index_val & IDX_MASK;
        end
    end

    always_comb
    begin
        case (em_kind_reg)
            OUT_OPAQUE, OUT_PLAYER: value_sel = ord_view;
            OUT_SHADOW:             value_sel = {12'd0, shadow_val_reg};
            OUT_INDEX:              value_sel = {10'd0, index_val};
            default:                value_sel = '0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_mode_reg  <= MODE_MAIN;
            packed_two_reg  <= 1'b0;
            row_active_reg  <= 1'b0;
            current_row_reg <= '0;
            column_pos_reg  <= '0;
            ordinal_reg     <= '0;
            shadow_rem_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_LAYER_MODE)
                begin
                    layer_mode_reg <= cfg_data;
                end
                else
                begin
                    packed_two_reg <= cfg_data[0];
                end
            end
            if (cmd.load || cmd.step)
            begin
                row_active_reg  <= row_active_next;
                current_row_reg <= current_row_next;
                column_pos_reg  <= column_pos_next;
                ordinal_reg     <= ordinal_next;
                shadow_rem_reg  <= shadow_rem_next;
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            em_kind_reg    <= em_kind_next;
            cnt_m1_reg     <= cnt_m1_next;
            idx_reg        <= '0;
            shadow_val_reg <= cmd_byte;
            block_reg      <= packed_block;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + 6'd1;
        end
        if (cmd.step)
        begin
            out_kind_reg <= em_kind_reg;
            pos_x_reg    <= (em_kind_reg == OUT_INDEX) ? 16'd0 : column_pos_reg;
            pos_y_reg    <= (em_kind_reg == OUT_INDEX) ? 16'd0 : current_row_reg;
            value_reg    <= value_sel;
            last_reg     <= (idx_reg == cnt_m1_reg);
        end
    end

    assign status.emits     = emits;
    assign status.last_step = (idx_reg == cnt_m1_reg);
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule
